// ===== design/xfbq_pkg.sv =====
package xfbq_pkg;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_FIR    = 2'd1,
        REQ_BIQ    = 2'd2,
        REQ_COMMIT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIR,
        S_BIQ,
        S_MIX,
        S_DONE
    } state_t;

    typedef struct packed {
        logic v;
        logic clr;
        logic neg;
    } mac_ctrl_t;

    localparam int BQ_TERMS = 5;
    localparam int LANES    = 4;

endpackage

// ===== design/crossfading_fir_biquad_stereo_filter.sv =====
// Channel   Ports                          Contents
// config    cfg_we, cfg_wdata              enable
// input     s_tvalid/s_tready/s_tdata/user request kind, samples, coefficient
// output    m_tvalid/m_tready/m_tdata/user filtered samples, status, bank
//
// Sample request: the FIR loop takes one tap per cycle in each of the four MAC lanes;
// during a fade the reciprocal-multiply mix follows.
// After reset a pass over every tap address clears the tap memories; s_tready stays low.
// A result waiting on m_tready holds the block in its done state.
module crossfading_fir_biquad_stereo_filter #(
    parameter int TAPS     = 64,
    parameter int FADE_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_left[15:0] sample_right[31:16] coef_index[37:32] coef_value[53:38]
    input  logic [55:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_left[15:0] out_right[31:16] active_bank_out[32]
    output logic [39:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);
    import xfbq_pkg::*;

    localparam int KW   = $clog2(TAPS);
    localparam int CNTW = $clog2(TAPS + 3);
    localparam int CW   = $clog2(FADE_LEN + 1);
    localparam int AW   = 32 + $clog2(TAPS) + 1;
    localparam logic signed [AW-1:0] HALF15 = AW'(16384);
    localparam logic signed [AW-1:0] HALF14 = AW'(8192);
    localparam logic signed [AW-1:0] SMAX   = AW'(32767);
    localparam logic signed [AW-1:0] SMIN   = ~SMAX;

    function automatic logic signed [15:0] rnd_sat(input logic signed [AW-1:0] a,
                                                   input logic sh15);
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] q;
        t = a + (sh15 ? HALF15 : HALF14);
        q = sh15 ? (t >>> 15) : (t >>> 14);
        if (q > SMAX) begin
            q = SMAX;
        end else if (q < SMIN) begin
            q = SMIN;
        end
        return q[15:0];
    endfunction

    state_t state_reg, state_next;
    logic   enable_reg;
    logic   active_bank_reg, active_bank_next;
    logic [CW-1:0]   fade_reg, fade_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] fill_reg, fill_next;
    logic [KW-1:0]   wp_reg, wp_next;
    logic [KW-1:0]   rdp_reg, rdp_next;
    logic signed [15:0] bq_coef_reg [2][BQ_TERMS];
    logic signed [15:0] bq_coef_next [2][BQ_TERMS];
    logic signed [15:0] hist_reg [2][2][4];
    logic signed [15:0] hist_next [2][2][4];
    logic signed [15:0] firy_reg [LANES];
    logic signed [15:0] firy_next [LANES];
    logic signed [15:0] res_l_reg, res_l_next, res_r_reg, res_r_next;
    status_t            res_st_reg, res_st_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic [31:0] dl_mem [TAPS];
    logic signed [15:0] tap0_mem [TAPS];
    logic signed [15:0] tap1_mem [TAPS];
    logic [31:0]        dl_rd_reg;
    logic signed [15:0] tap0_rd_reg, tap1_rd_reg;
    logic rd_v_reg, rd_first_reg, rd_ok_reg;

    logic               dl_we, tw0_en, tw1_en;
    logic [KW-1:0]      tw_addr;
    logic signed [15:0] tw_data;
    logic               issue;

    req_t               req;
    logic signed [15:0] in_l, in_r, in_val;
    logic [8:0]         idx9;
    logic               in_go, back, fading, out_free;

    mac_ctrl_t          lane_ctrl;
    logic signed [15:0] lane_coef [LANES];
    logic signed [15:0] lane_data [LANES];
    logic signed [AW-1:0] lane_acc [LANES];
    logic signed [15:0] lane_y [LANES];
    logic [2:0]         jsel;

    logic               mix_start, mix_done_l, mix_done_r;
    logic signed [15:0] mix_y_l, mix_y_r;

    assign req      = req_t'(s_tuser);
    assign in_l     = s_tdata[15:0];
    assign in_r     = s_tdata[31:16];
    assign idx9     = {3'b000, s_tdata[37:32]};
    assign in_val   = s_tdata[53:38];
    assign s_tready = (state_reg == S_IDLE);
    assign in_go    = s_tvalid && s_tready;
    assign back     = ~active_bank_reg;
    assign fading   = (fade_reg != '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = (state_reg == S_FIR) && (cnt_reg < CNTW'(TAPS));
    assign jsel     = 3'(cnt_reg - 1'b1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (cnt_reg == CNTW'(TAPS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_go) begin
                    if (req == REQ_SAMPLE && enable_reg) state_next = S_FIR;
                    else state_next = S_DONE;
                end
            end
            S_FIR: begin
                if (cnt_reg == CNTW'(TAPS + 1)) state_next = S_BIQ;
            end
            S_BIQ: begin
                if (cnt_reg == CNTW'(7)) state_next = fading ? S_MIX : S_DONE;
            end
            S_MIX: begin
                if (mix_done_l) state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // lane operands
    always_comb begin
        lane_ctrl = '0;
        for (int l = 0; l < LANES; l++) begin
            lane_coef[l] = '0;
            lane_data[l] = '0;
        end
        if (state_reg == S_BIQ) begin
            lane_ctrl.v   = (cnt_reg >= CNTW'(1)) && (cnt_reg <= CNTW'(BQ_TERMS));
            lane_ctrl.clr = (cnt_reg == CNTW'(1));
            lane_ctrl.neg = (cnt_reg >= CNTW'(4));
            for (int l = 0; l < LANES; l++) begin
                case (jsel) inside
                    3'd0: begin
                        lane_coef[l] = bq_coef_reg[active_bank_reg ^ (l >= 2)][0];
                        lane_data[l] = firy_reg[l];
                    end
                    [3'd1:3'd4]: begin
                        lane_coef[l] = bq_coef_reg[active_bank_reg ^ (l >= 2)][jsel];
                        lane_data[l] =
                            hist_reg[active_bank_reg ^ (l >= 2)][l % 2][2'(jsel - 3'd1)];
                    end
                    default: begin
                        lane_coef[l] = '0;
                        lane_data[l] = '0;
                    end
                endcase
            end
        end else begin
            lane_ctrl.v   = rd_v_reg;
            lane_ctrl.clr = rd_first_reg;
            for (int l = 0; l < LANES; l++) begin
                lane_coef[l] = ((active_bank_reg ^ (l >= 2)) == 1'b1) ? tap1_rd_reg
                                                                       : tap0_rd_reg;
                lane_data[l] = !rd_ok_reg ? 16'sd0
                             : (l % 2 == 1) ? dl_rd_reg[31:16] : dl_rd_reg[15:0];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        xfbq_mac #(.AW(AW)) u_mac (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .coef    (lane_coef[g]),
            .data    (lane_data[g]),
            .acc     (lane_acc[g])
        );
        assign lane_y[g] = rnd_sat(lane_acc[g], 1'b0);
    end

    assign mix_start = (state_reg == S_BIQ) && (cnt_reg == CNTW'(7)) && fading;

    xfbq_mix #(.FADE_LEN(FADE_LEN)) u_mix_l (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .old_s   (lane_y[0]),
        .new_s   (lane_y[2]),
        .count   (fade_reg),
        .done    (mix_done_l),
        .y       (mix_y_l)
    );

    xfbq_mix #(.FADE_LEN(FADE_LEN)) u_mix_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .old_s   (lane_y[1]),
        .new_s   (lane_y[3]),
        .count   (fade_reg),
        .done    (mix_done_r),
        .y       (mix_y_r)
    );

    // datapath and output control
    always_comb begin
        active_bank_next = active_bank_reg;
        fade_next        = fade_reg;
        cnt_next         = cnt_reg;
        fill_next        = fill_reg;
        wp_next          = wp_reg;
        rdp_next         = rdp_reg;
        bq_coef_next     = bq_coef_reg;
        hist_next        = hist_reg;
        firy_next        = firy_reg;
        res_l_next       = res_l_reg;
        res_r_next       = res_r_reg;
        res_st_next      = res_st_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        dl_we            = 1'b0;
        tw0_en           = 1'b0;
        tw1_en           = 1'b0;
        tw_addr          = idx9[KW-1:0];
        tw_data          = in_val;

        unique case (state_reg)
            S_CLEAR: begin
                tw0_en   = 1'b1;
                tw1_en   = 1'b1;
                tw_addr  = cnt_reg[KW-1:0];
                tw_data  = '0;
                cnt_next = (cnt_reg == CNTW'(TAPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            S_IDLE: begin
                if (in_go) begin
                    res_l_next  = '0;
                    res_r_next  = '0;
                    res_st_next = ST_ACCEPT;
                    if (req == REQ_SAMPLE) begin
                        res_st_next = ST_DONE;
                        if (!enable_reg) begin
                            res_l_next = in_l;
                            res_r_next = in_r;
                        end else begin
                            dl_we     = 1'b1;
                            rdp_next  = wp_reg;
                            wp_next   = (wp_reg == KW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                            fill_next = (fill_reg == CNTW'(TAPS)) ? fill_reg
                                                                  : fill_reg + 1'b1;
                            cnt_next  = '0;
                        end
                    end else if (fading) begin
                        res_st_next = ST_REJECT;
                    end else begin
                        case (req)
                            REQ_FIR: begin
                                if (idx9 < 9'(TAPS)) begin
                                    tw0_en = (back == 1'b0);
                                    tw1_en = (back == 1'b1);
                                end
                            end
                            REQ_BIQ: begin
                                if (idx9 < 9'(BQ_TERMS)) begin
                                    bq_coef_next[back][idx9[2:0]] = in_val;
                                end
                            end
                            default: begin
                                hist_next[back] = hist_reg[active_bank_reg];
                                fade_next       = CW'(FADE_LEN);
                            end
                        endcase
                    end
                end
            end
            S_FIR: begin
                if (issue) begin
                    rdp_next = (rdp_reg == '0) ? KW'(TAPS - 1) : rdp_reg - 1'b1;
                end
                cnt_next = (cnt_reg == CNTW'(TAPS + 1)) ? '0 : cnt_reg + 1'b1;
            end
            S_BIQ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0) begin
                    for (int l = 0; l < LANES; l++) begin
                        firy_next[l] = rnd_sat(lane_acc[l], 1'b1);
                    end
                end
                if (cnt_reg == CNTW'(7)) begin
                    cnt_next = '0;
                    for (int l = 0; l < LANES; l++) begin
                        if (l < 2 || fading) begin
                            hist_next[active_bank_reg ^ (l >= 2)][l % 2][1] =
                                hist_reg[active_bank_reg ^ (l >= 2)][l % 2][0];
                            hist_next[active_bank_reg ^ (l >= 2)][l % 2][0] = firy_reg[l];
                            hist_next[active_bank_reg ^ (l >= 2)][l % 2][3] =
                                hist_reg[active_bank_reg ^ (l >= 2)][l % 2][2];
                            hist_next[active_bank_reg ^ (l >= 2)][l % 2][2] = lane_y[l];
                        end
                    end
                    res_l_next = lane_y[0];
                    res_r_next = lane_y[1];
                end
            end
            S_MIX: begin
                if (mix_done_l) begin
                    res_l_next = mix_y_l;
                    res_r_next = mix_y_r;
                    fade_next  = fade_reg - 1'b1;
                    if (fade_reg == CW'(1)) active_bank_next = back;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, active_bank_reg, res_r_reg, res_l_reg};
                    m_tuser_next  = res_st_reg;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            enable_reg      <= 1'b1;
            active_bank_reg <= 1'b0;
            fade_reg        <= '0;
            cnt_reg         <= '0;
            fill_reg        <= '0;
            wp_reg          <= '0;
            rdp_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            rd_v_reg        <= 1'b0;
            rd_first_reg    <= 1'b0;
            rd_ok_reg       <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                for (int j = 0; j < BQ_TERMS; j++) bq_coef_reg[b][j] <= '0;
                for (int c = 0; c < 2; c++) begin
                    for (int s = 0; s < 4; s++) hist_reg[b][c][s] <= '0;
                end
            end
        end else begin
            state_reg       <= state_next;
            if (cfg_we) enable_reg <= cfg_wdata;
            active_bank_reg <= active_bank_next;
            fade_reg        <= fade_next;
            cnt_reg         <= cnt_next;
            fill_reg        <= fill_next;
            wp_reg          <= wp_next;
            rdp_reg         <= rdp_next;
            m_tvalid_reg    <= m_tvalid_next;
            rd_v_reg        <= issue;
            rd_first_reg    <= issue && (cnt_reg == '0);
            rd_ok_reg       <= cnt_reg < fill_reg;
            bq_coef_reg     <= bq_coef_next;
            hist_reg        <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        firy_reg    <= firy_next;
        res_l_reg   <= res_l_next;
        res_r_reg   <= res_r_next;
        res_st_reg  <= res_st_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // delay line and tap banks
    always_ff @(posedge aclk) begin
        if (dl_we) dl_mem[wp_reg] <= {in_r, in_l};
        if (tw0_en) tap0_mem[tw_addr] <= tw_data;
        if (tw1_en) tap1_mem[tw_addr] <= tw_data;
        dl_rd_reg   <= dl_mem[rdp_reg];
        tap0_rd_reg <= tap0_mem[cnt_reg[KW-1:0]];
        tap1_rd_reg <= tap1_mem[cnt_reg[KW-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_fade_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fade_reg <= CW'(FADE_LEN))
        else $error("fade count above fade length");

    a_bank_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MIX && mix_done_l && fade_reg == CW'(1))
        |=> active_bank_reg != $past(active_bank_reg))
        else $error("banks did not swap at end of fade");

    a_mix_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_done_l == mix_done_r)
        else $error("left and right mix out of step");
`endif

endmodule

// ===== design/xfbq_mac.sv =====
module xfbq_mac #(
    parameter int AW = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  xfbq_pkg::mac_ctrl_t  ctrl,
    input  logic signed [15:0]   coef,
    input  logic signed [15:0]   data,
    output logic signed [AW-1:0] acc
);
    import xfbq_pkg::*;

    logic signed [31:0]   prod_reg;
    mac_ctrl_t            ctrl_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] base;

    always_comb begin
        base     = ctrl_reg.clr ? '0 : acc_reg;
        acc_next = acc_reg;
        if (ctrl_reg.v) begin
            acc_next = ctrl_reg.neg ? base - AW'(prod_reg) : base + AW'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef * data;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== design/xfbq_mix.sv =====
module xfbq_mix #(
    parameter int FADE_LEN = 256,
    localparam int CW = $clog2(FADE_LEN + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] old_s,
    input  logic signed [15:0] new_s,
    input  logic [CW-1:0]      count,
    output logic               done,
    output logic signed [15:0] y
);
    localparam int NW   = CW + 17;
    localparam int SUMW = CW + 18;
    localparam int LG   = $clog2(FADE_LEN);
    localparam int SH   = NW + LG;
    localparam int MW   = NW + 2;
    localparam int PW   = NW + MW;
    localparam logic signed [SUMW-1:0] BIAS = SUMW'(32768 * FADE_LEN + FADE_LEN / 2);
    localparam longint RECIP_L =
        ((longint'(1) <<< SH) + longint'(FADE_LEN) - 1) / longint'(FADE_LEN);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic signed [CW+16:0] p_old_reg, p_new_reg;
    logic signed [CW:0]    c_old, c_new;
    logic signed [SUMW-1:0] sum;
    logic                  pv_reg, nv_reg, done_reg;
    logic [NW-1:0]         num_reg;
    logic [PW-1:0]         q_reg;

    always_comb begin
        c_old = signed'({1'b0, count});
        c_new = signed'({1'b0, CW'(FADE_LEN) - count});
        sum   = SUMW'(p_old_reg) + SUMW'(p_new_reg) + BIAS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg   <= 1'b0;
            nv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            pv_reg   <= start;
            nv_reg   <= pv_reg;
            done_reg <= nv_reg;
        end
    end

    // floor divide by the fade length as a reciprocal multiply,
    // exact over the whole numerator range
    always_ff @(posedge aclk) begin
        p_old_reg <= old_s * c_old;
        p_new_reg <= new_s * c_new;
        if (pv_reg) begin
            num_reg <= NW'(sum);
        end
        if (nv_reg) begin
            q_reg <= PW'(num_reg) * PW'(RECIP);
        end
    end

    assign done = done_reg;
    assign y    = {~q_reg[SH+15], q_reg[SH+14:SH]};

endmodule
